### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while the reset signal is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, switched off while the reset signal is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

### hw/rtl/rlsc_pkg.sv
// Package of the radio link session controller: codes, record types and defaults.
package rlsc_pkg;

   // Default timer width and register reset values.
   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam logic [15:0] HS_TO_RESET   = 16'd5000;
   localparam logic [15:0] AUTH_TO_RESET = 16'd5000;
   localparam logic [15:0] CFG_TO_RESET  = 16'd5000;
   localparam logic [15:0] TX_TO_RESET   = 16'd10000;
   localparam logic [15:0] PING_IV_RESET = 16'd15000;
   localparam logic [15:0] PONG_TO_RESET = 16'd10000;

   // Depth of the queue between the event front end and the message back end.
   localparam int QUEUE_DEPTH = 2;

   // Stream widths.
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;

   // Event kinds carried on req_tuser.
   localparam logic [2:0] MODE_OPEN    = 3'd0;
   localparam logic [2:0] MODE_FRAME   = 3'd1;
   localparam logic [2:0] MODE_TICK    = 3'd2;
   localparam logic [2:0] MODE_TXDONE  = 3'd3;
   localparam logic [2:0] MODE_BACKEND = 3'd4;
   localparam logic [2:0] MODE_RX      = 3'd5;
   localparam logic [2:0] MODE_PARSER  = 3'd6;

   // Received frame types.
   localparam logic [2:0] FT_HELLO     = 3'd0;
   localparam logic [2:0] FT_AUTH_RESP = 3'd1;
   localparam logic [2:0] FT_CONFIGURE = 3'd2;
   localparam logic [2:0] FT_TX_REQ    = 3'd3;
   localparam logic [2:0] FT_PONG      = 3'd4;
   localparam logic [2:0] FT_ERROR     = 3'd5;
   localparam logic [2:0] FT_SERVER    = 3'd6;

   // Emitted message types.
   localparam logic [2:0] MSG_NONE      = 3'd0;
   localparam logic [2:0] MSG_GREET_ACK = 3'd1;
   localparam logic [2:0] MSG_CHALLENGE = 3'd2;
   localparam logic [2:0] MSG_AUTH_RES  = 3'd3;
   localparam logic [2:0] MSG_CFG_RES   = 3'd4;
   localparam logic [2:0] MSG_TX_RES    = 3'd5;
   localparam logic [2:0] MSG_RX_PKT    = 3'd6;
   localparam logic [2:0] MSG_KEEPALIVE = 3'd7;

   // Result codes.
   localparam logic [1:0] CODE_OK          = 2'd0;
   localparam logic [1:0] CODE_FAIL        = 2'd1;
   localparam logic [1:0] CODE_UNSUPPORTED = 2'd2;

   // Close reasons.
   localparam logic [3:0] CC_NONE      = 4'd0;
   localparam logic [3:0] CC_MALFORMED = 4'd2;
   localparam logic [3:0] CC_PARSER    = 4'd3;
   localparam logic [3:0] CC_BADSTATE  = 4'd4;
   localparam logic [3:0] CC_REMOTE    = 4'd5;
   localparam logic [3:0] CC_AUTHFAIL  = 4'd6;
   localparam logic [3:0] CC_AUTHERR   = 4'd7;
   localparam logic [3:0] CC_CFGFAIL   = 4'd8;
   localparam logic [3:0] CC_BACKEND   = 4'd9;
   localparam logic [3:0] CC_HS_TO     = 4'd10;
   localparam logic [3:0] CC_AUTH_TO   = 4'd11;
   localparam logic [3:0] CC_CFG_TO    = 4'd12;
   localparam logic [3:0] CC_PONG_TO   = 4'd13;
   localparam logic [3:0] CC_TX_TO     = 4'd14;

   // Configuration register indexes.
   localparam logic [2:0] REG_AUTH_REQ = 3'd0;
   localparam logic [2:0] REG_HS_TO    = 3'd1;
   localparam logic [2:0] REG_AUTH_TO  = 3'd2;
   localparam logic [2:0] REG_CFG_TO   = 3'd3;
   localparam logic [2:0] REG_TX_TO    = 3'd4;
   localparam logic [2:0] REG_PING_IV  = 3'd5;
   localparam logic [2:0] REG_PONG_TO  = 3'd6;

   // Session phase.
   typedef enum logic [2:0] {
      PH_HELLO  = 3'd0,
      PH_AUTH   = 3'd1,
      PH_CFG    = 3'd2,
      PH_READY  = 3'd3,
      PH_CLOSED = 3'd4
   } phase_type;

   // Outcome of one event, as handed from the front end to the back end.
   typedef struct packed {
      logic       two;
      logic [2:0] type0;
      logic [15:0] seq0;
      logic [1:0] code0;
      logic [2:0] type1;
      logic [1:0] code1;
      phase_type  phase;
      logic [3:0] cause;
      logic       abandon;
   } rec_type;

   // One result item as held in the output register.
   typedef struct packed {
      logic [2:0] msg_type;
      logic [15:0] seq;
      logic [1:0] code;
      phase_type  phase;
      logic [3:0] cause;
      logic       abandon;
      logic       last;
   } item_type;

endpackage

### hw/rtl/rlsc_queue.sv
// Short queue of event outcomes between the front end and the back end.
module rlsc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rlsc_pkg::rec_type push_rec,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rlsc_pkg::rec_type pop_rec
);

   localparam int Depth = rlsc_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   rlsc_pkg::rec_type store_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

### hw/rtl/rlsc_front.sv
// Front end: configuration registers, session state and classification of each event.
module rlsc_front #(
   parameter int TIMER_WIDTH = rlsc_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rlsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [2:0]                    req_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [15:0]                   csr_data,
   output logic                          push_valid,
   input  logic                          push_ready,
   output rlsc_pkg::rec_type              push_rec
);

   localparam logic [32:0] TimerTop = (33'd1 << TIMER_WIDTH) - 33'd1;

   // Saturating load of a 16-bit timeout into a countdown.
   function automatic logic [TIMER_WIDTH-1:0] load_timer(input logic [15:0] v);
      logic [32:0] wide;
      wide = {17'd0, v};
      if (wide > TimerTop) begin
         load_timer = TimerTop[TIMER_WIDTH-1:0];
      end else begin
         load_timer = wide[TIMER_WIDTH-1:0];
      end
   endfunction

   // Countdown step that stops at zero.
   function automatic logic [TIMER_WIDTH-1:0] count_down(input logic [TIMER_WIDTH-1:0] v);
      count_down = (v == '0) ? '0 : v - 1'b1;
   endfunction

   // Unpacked event fields.
   logic [2:0]  ev_mode;
   logic [2:0]  frame_type;
   logic        frame_valid, auth_ok, nonce_ok, config_valid, config_matches, submit_ok;
   logic [15:0] frame_seq;
   logic [1:0]  tx_outcome;
   logic        rx_len_ok;
   logic        accept;

   assign ev_mode        = req_tuser;
   assign frame_type     = req_tdata[2:0];
   assign frame_valid    = req_tdata[3];
   assign auth_ok        = req_tdata[4];
   assign nonce_ok       = req_tdata[5];
   assign config_valid   = req_tdata[6];
   assign config_matches = req_tdata[7];
   assign submit_ok      = req_tdata[8];
   assign frame_seq      = req_tdata[24:9];
   assign tx_outcome     = req_tdata[26:25];
   assign rx_len_ok      = req_tdata[27];

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = req_tvalid;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   logic        auth_req_ff;
   logic [15:0] hs_to_ff, auth_to_ff, cfg_to_ff, tx_to_ff, ping_iv_ff, pong_to_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auth_req_ff <= 1'b0;
         hs_to_ff    <= rlsc_pkg::HS_TO_RESET;
         auth_to_ff  <= rlsc_pkg::AUTH_TO_RESET;
         cfg_to_ff   <= rlsc_pkg::CFG_TO_RESET;
         tx_to_ff    <= rlsc_pkg::TX_TO_RESET;
         ping_iv_ff  <= rlsc_pkg::PING_IV_RESET;
         pong_to_ff  <= rlsc_pkg::PONG_TO_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rlsc_pkg::REG_AUTH_REQ: auth_req_ff <= csr_data[0];
            rlsc_pkg::REG_HS_TO:    hs_to_ff    <= csr_data;
            rlsc_pkg::REG_AUTH_TO:  auth_to_ff  <= csr_data;
            rlsc_pkg::REG_CFG_TO:   cfg_to_ff   <= csr_data;
            rlsc_pkg::REG_TX_TO:    tx_to_ff    <= csr_data;
            rlsc_pkg::REG_PING_IV:  ping_iv_ff  <= csr_data;
            rlsc_pkg::REG_PONG_TO:  pong_to_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Session state.
   rlsc_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  close_ff, close_in;
   logic        pdo_ff, pdo_in;
   logic [TIMER_WIDTH-1:0] pcnt_ff, pcnt_in;
   logic [3:0]  pexp_ff, pexp_in;
   logic        txb_ff, txb_in;
   logic [15:0] txseq_ff, txseq_in;
   logic [TIMER_WIDTH-1:0] txcnt_ff, txcnt_in;
   logic        pp_ff, pp_in;
   logic [TIMER_WIDTH-1:0] ping_ff, ping_in;
   logic [TIMER_WIDTH-1:0] pong_ff, pong_in;

   // Next state and the outcome record of the event on the port.
   always_comb begin
      logic shut_req;
      logic [3:0] shut_why;
      logic abandon;
      logic two;
      logic [2:0] type0, type1;
      logic [15:0] seq0;
      logic [1:0] code0, code1;
      logic [TIMER_WIDTH-1:0] pc_d, tx_d, ping_d, pong_d;

      phase_in = phase_ff;
      close_in = close_ff;
      pdo_in   = pdo_ff;
      pcnt_in  = pcnt_ff;
      pexp_in  = pexp_ff;
      txb_in   = txb_ff;
      txseq_in = txseq_ff;
      txcnt_in = txcnt_ff;
      pp_in    = pp_ff;
      ping_in  = ping_ff;
      pong_in  = pong_ff;
      shut_req = 1'b0;
      shut_why = rlsc_pkg::CC_NONE;
      abandon  = 1'b0;
      two      = 1'b0;
      type0    = rlsc_pkg::MSG_NONE;
      seq0     = '0;
      code0    = rlsc_pkg::CODE_OK;
      type1    = rlsc_pkg::MSG_NONE;
      code1    = rlsc_pkg::CODE_OK;
      pc_d     = pdo_ff ? count_down(pcnt_ff) : pcnt_ff;
      tx_d     = txb_ff ? count_down(txcnt_ff) : txcnt_ff;
      ping_d   = pp_ff ? ping_ff : count_down(ping_ff);
      pong_d   = pp_ff ? count_down(pong_ff) : pong_ff;

      unique case (ev_mode)
         rlsc_pkg::MODE_OPEN: begin
            phase_in = rlsc_pkg::PH_HELLO;
            close_in = rlsc_pkg::CC_NONE;
            txb_in   = 1'b0;
            pp_in    = 1'b0;
            pdo_in   = 1'b1;
            pcnt_in  = load_timer(hs_to_ff);
            pexp_in  = rlsc_pkg::CC_HS_TO;
         end
         rlsc_pkg::MODE_FRAME: begin
            if (phase_ff != rlsc_pkg::PH_CLOSED) begin
               if (!frame_valid) begin
                  shut_req = 1'b1;
                  shut_why = rlsc_pkg::CC_MALFORMED;
               end else if (frame_type >= rlsc_pkg::FT_SERVER) begin
                  shut_req = 1'b1;
                  shut_why = rlsc_pkg::CC_BADSTATE;
               end else if (frame_type == rlsc_pkg::FT_ERROR) begin
                  shut_req = 1'b1;
                  shut_why = rlsc_pkg::CC_REMOTE;
               end else begin
                  unique case (phase_ff)
                     rlsc_pkg::PH_HELLO: begin
                        if (frame_type != rlsc_pkg::FT_HELLO) begin
                           shut_req = 1'b1;
                           shut_why = rlsc_pkg::CC_BADSTATE;
                        end else begin
                           type0 = rlsc_pkg::MSG_GREET_ACK;
                           if (auth_req_ff) begin
                              if (!nonce_ok) begin
                                 shut_req = 1'b1;
                                 shut_why = rlsc_pkg::CC_AUTHERR;
                              end else begin
                                 two      = 1'b1;
                                 type1    = rlsc_pkg::MSG_CHALLENGE;
                                 phase_in = rlsc_pkg::PH_AUTH;
                                 pdo_in   = 1'b1;
                                 pcnt_in  = load_timer(auth_to_ff);
                                 pexp_in  = rlsc_pkg::CC_AUTH_TO;
                              end
                           end else begin
                              two      = 1'b1;
                              type1    = rlsc_pkg::MSG_AUTH_RES;
                              phase_in = rlsc_pkg::PH_CFG;
                              pdo_in   = 1'b1;
                              pcnt_in  = load_timer(cfg_to_ff);
                              pexp_in  = rlsc_pkg::CC_CFG_TO;
                           end
                        end
                     end
                     rlsc_pkg::PH_AUTH: begin
                        if (frame_type != rlsc_pkg::FT_AUTH_RESP) begin
                           shut_req = 1'b1;
                           shut_why = rlsc_pkg::CC_BADSTATE;
                        end else if (auth_ok) begin
                           type0    = rlsc_pkg::MSG_AUTH_RES;
                           phase_in = rlsc_pkg::PH_CFG;
                           pdo_in   = 1'b1;
                           pcnt_in  = load_timer(cfg_to_ff);
                           pexp_in  = rlsc_pkg::CC_CFG_TO;
                        end else begin
                           type0    = rlsc_pkg::MSG_AUTH_RES;
                           code0    = rlsc_pkg::CODE_FAIL;
                           shut_req = 1'b1;
                           shut_why = rlsc_pkg::CC_AUTHFAIL;
                        end
                     end
                     rlsc_pkg::PH_CFG: begin
                        if (frame_type != rlsc_pkg::FT_CONFIGURE) begin
                           shut_req = 1'b1;
                           shut_why = rlsc_pkg::CC_BADSTATE;
                        end else if (!config_valid) begin
                           type0    = rlsc_pkg::MSG_CFG_RES;
                           code0    = rlsc_pkg::CODE_FAIL;
                           shut_req = 1'b1;
                           shut_why = rlsc_pkg::CC_CFGFAIL;
                        end else if (!config_matches) begin
                           type0    = rlsc_pkg::MSG_CFG_RES;
                           code0    = rlsc_pkg::CODE_UNSUPPORTED;
                           shut_req = 1'b1;
                           shut_why = rlsc_pkg::CC_CFGFAIL;
                        end else begin
                           type0    = rlsc_pkg::MSG_CFG_RES;
                           phase_in = rlsc_pkg::PH_READY;
                           pdo_in   = 1'b0;
                           pp_in    = 1'b0;
                           ping_in  = load_timer(ping_iv_ff);
                        end
                     end
                     default: begin
                        // Ready phase: pong and transmit request are the only frames taken.
                        if (frame_type == rlsc_pkg::FT_PONG) begin
                           if (!pp_ff) begin
                              shut_req = 1'b1;
                              shut_why = rlsc_pkg::CC_BADSTATE;
                           end else begin
                              pp_in   = 1'b0;
                              ping_in = load_timer(ping_iv_ff);
                           end
                        end else if (frame_type == rlsc_pkg::FT_TX_REQ) begin
                           if (txb_ff) begin
                              shut_req = 1'b1;
                              shut_why = rlsc_pkg::CC_BADSTATE;
                           end else begin
                              txseq_in = frame_seq;
                              if (!submit_ok) begin
                                 shut_req = 1'b1;
                                 shut_why = rlsc_pkg::CC_BACKEND;
                              end else begin
                                 txb_in   = 1'b1;
                                 txcnt_in = load_timer(tx_to_ff);
                              end
                           end
                        end else begin
                           shut_req = 1'b1;
                           shut_why = rlsc_pkg::CC_BADSTATE;
                        end
                     end
                  endcase
               end
            end
         end
         rlsc_pkg::MODE_TICK: begin
            if (phase_ff != rlsc_pkg::PH_CLOSED) begin
               pcnt_in  = pc_d;
               txcnt_in = tx_d;
               ping_in  = ping_d;
               pong_in  = pong_d;
               if (pdo_ff && pc_d == '0) begin
                  shut_req = 1'b1;
                  shut_why = pexp_ff;
               end else if (phase_ff == rlsc_pkg::PH_READY) begin
                  if (txb_ff && tx_d == '0) begin
                     shut_req = 1'b1;
                     shut_why = rlsc_pkg::CC_TX_TO;
                     abandon  = 1'b1;
                  end else if (pp_ff) begin
                     if (pong_d == '0) begin
                        shut_req = 1'b1;
                        shut_why = rlsc_pkg::CC_PONG_TO;
                     end
                  end else if (ping_d == '0) begin
                     type0   = rlsc_pkg::MSG_KEEPALIVE;
                     pp_in   = 1'b1;
                     pong_in = load_timer(pong_to_ff);
                  end
               end
            end
         end
         rlsc_pkg::MODE_TXDONE: begin
            if (txb_ff) begin
               txb_in = 1'b0;
               type0  = rlsc_pkg::MSG_TX_RES;
               seq0   = txseq_ff;
               code0  = tx_outcome;
            end
         end
         rlsc_pkg::MODE_BACKEND: begin
            shut_req = 1'b1;
            shut_why = rlsc_pkg::CC_BACKEND;
         end
         rlsc_pkg::MODE_RX: begin
            if (phase_ff == rlsc_pkg::PH_READY && rx_len_ok) begin
               type0 = rlsc_pkg::MSG_RX_PKT;
            end
         end
         rlsc_pkg::MODE_PARSER: begin
            shut_req = 1'b1;
            shut_why = rlsc_pkg::CC_PARSER;
         end
         default: ;
      endcase

      // A close only takes effect from an open session, so the first reason sticks.
      if (shut_req && phase_ff != rlsc_pkg::PH_CLOSED) begin
         close_in = shut_why;
         phase_in = rlsc_pkg::PH_CLOSED;
         pdo_in   = 1'b0;
         txb_in   = 1'b0;
      end

      push_rec.two     = two;
      push_rec.type0   = type0;
      push_rec.seq0    = seq0;
      push_rec.code0   = code0;
      push_rec.type1   = type1;
      push_rec.code1   = code1;
      push_rec.phase   = phase_in;
      push_rec.cause   = close_in;
      push_rec.abandon = abandon;
   end

   // State register, updated once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rlsc_pkg::PH_CLOSED;
         close_ff <= rlsc_pkg::CC_NONE;
         pdo_ff   <= 1'b0;
         pcnt_ff  <= '0;
         pexp_ff  <= rlsc_pkg::CC_NONE;
         txb_ff   <= 1'b0;
         txseq_ff <= '0;
         txcnt_ff <= '0;
         pp_ff    <= 1'b0;
         ping_ff  <= '0;
         pong_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         close_ff <= close_in;
         pdo_ff   <= pdo_in;
         pcnt_ff  <= pcnt_in;
         pexp_ff  <= pexp_in;
         txb_ff   <= txb_in;
         txseq_ff <= txseq_in;
         txcnt_ff <= txcnt_in;
         pp_ff    <= pp_in;
         ping_ff  <= ping_in;
         pong_ff  <= pong_in;
      end
   end

endmodule

### hw/rtl/rlsc_back.sv
// Back end: turns each event outcome into one or two result items on the output register.
module rlsc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  rlsc_pkg::rec_type              pop_rec,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rlsc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [2:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   logic rsp_valid_ff, rsp_valid_in;
   logic second_ff, second_in;
   rlsc_pkg::item_type out_ff, out_in;
   rlsc_pkg::item_type hold_ff, hold_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready = out_free && !second_ff;

   // Output register load: the held second item first, then the next queued outcome.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      second_in    = second_ff;
      out_in       = out_ff;
      hold_in      = hold_ff;
      if (out_free) begin
         if (second_ff) begin
            rsp_valid_in = 1'b1;
            out_in       = hold_ff;
            second_in    = 1'b0;
         end else if (pop_valid) begin
            rsp_valid_in     = 1'b1;
            out_in.msg_type  = pop_rec.type0;
            out_in.seq       = pop_rec.seq0;
            out_in.code      = pop_rec.code0;
            out_in.phase     = pop_rec.phase;
            out_in.cause     = pop_rec.cause;
            out_in.abandon   = pop_rec.abandon;
            out_in.last      = !pop_rec.two;
            second_in        = pop_rec.two;
            hold_in.msg_type = pop_rec.type1;
            hold_in.seq      = '0;
            hold_in.code     = pop_rec.code1;
            hold_in.phase    = pop_rec.phase;
            hold_in.cause    = pop_rec.cause;
            hold_in.abandon  = pop_rec.abandon;
            hold_in.last     = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   // Item payloads carry no reset.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ff.msg_type;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {6'd0, out_ff.abandon, out_ff.cause, out_ff.phase,
                        out_ff.code, out_ff.seq};

endmodule

### hw/rtl/radio_link_session_controller.sv
// Top level of the radio link session controller.
//
// Usage:
// - req_* carries one session event per transaction: the event kind on req_tuser and
//   the frame flags, frame sequence, transmit outcome and packet length check on req_tdata.
// - rsp_* returns one or two message descriptors per event; rsp_tlast marks the final
//   item of an event. An event that emits no message returns a single status item.
// - csr_* writes one configuration register per transaction; csr_ready is always high.
//   Registers must be written only while no event is in flight; the block does not check.
// Flow and throughput: an event is classified in the cycle it is accepted and enters
// the queue at that edge; its first item then passes from the queue into the output
// register, and a second item follows it from the hold register.
// While rsp_tready is high the output register drains one item per cycle, so events
// with one item sustain one transaction per cycle; a held second item blocks the next.
// Stalls: a two-entry queue sits between the event front end and the item back end;
// while rsp_tready is low the queue fills and req_tready then drops until space frees.
// Reset: control and state registers take their reset values, the session is closed
// with no close reason, the queue and the output register are empty and rsp_tvalid is low.
module radio_link_session_controller #(
   parameter int TIMER_WIDTH = rlsc_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // frame_type, frame_valid, auth_ok, nonce_ok, config_valid, config_matches,
   // submit_ok, frame_seq, tx_outcome, rx_len_ok, zero fill
   input  logic [rlsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [2:0]                    req_tuser,  // mode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // msg_seq, msg_code, phase_now, close_cause, abandon_tx, zero fill
   output logic [rlsc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [2:0]                    rsp_tuser,  // msg_type
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [15:0]                   csr_data
);

   logic              push_valid, push_ready;
   rlsc_pkg::rec_type push_rec;
   logic              pop_valid, pop_ready;
   rlsc_pkg::rec_type pop_rec;

   // Event classification and session state.
   rlsc_front #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec)
   );

   // Outcome queue.
   rlsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   // Result item emission.
   rlsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/rlsc_checker.sv
// Port-level checks of the session controller's result channel, bound to the top level.
`include "assert_macros.svh"

module rlsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rlsc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]                    rsp_tuser,
   input logic                          rsp_tlast
);

   logic [2:0] phase_now;
   logic [3:0] close_cause;
   logic       abandon_tx;

   assign phase_now   = rsp_tdata[20:18];
   assign close_cause = rsp_tdata[24:21];
   assign abandon_tx  = rsp_tdata[25];

   // Nothing is offered in the cycle after reset.
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

   // A stalled item stays on the port unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // An abandoned transmit always comes with the transmit-timeout close.
   `ASSERT_IMPLY(a_abandon_close, clock, reset, rsp_tvalid && abandon_tx, phase_now == rlsc_pkg::PH_CLOSED && close_cause == rlsc_pkg::CC_TX_TO)

   // An open session never reports a close reason.
   `ASSERT_IMPLY(a_open_no_cause, clock, reset, rsp_tvalid && phase_now != rlsc_pkg::PH_CLOSED, close_cause == rlsc_pkg::CC_NONE)

   // A challenge ends its event and leaves the session waiting for the auth response.
   `ASSERT_IMPLY(a_challenge_last, clock, reset, rsp_tvalid && rsp_tuser == rlsc_pkg::MSG_CHALLENGE, rsp_tlast && phase_now == rlsc_pkg::PH_AUTH)

endmodule

bind radio_link_session_controller rlsc_checker u_rlsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### dv/radio_link_session_controller_tb.sv
// Self-checking testbench of the radio link session controller, with its own session predictor.
module radio_link_session_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlsc_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int GAP_PCT      = 36;

   // One session event as the testbench holds it before packing it onto the bus.
   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  ftype;
      logic        fvalid;
      logic        auth_ok;
      logic        nonce_ok;
      logic        cfg_valid;
      logic        cfg_match;
      logic        submit_ok;
      logic [15:0] fseq;
      logic [1:0]  outcome;
      logic        rx_ok;
   } sess_evt_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // frame_type, frame_valid, auth_ok, nonce_ok, config_valid, config_matches,
   // submit_ok, frame_seq, tx_outcome, rx_len_ok, zero fill
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [2:0]             req_tuser = '0;  // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // msg_seq, msg_code, phase_now, close_cause, abandon_tx, zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;  // msg_type
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [2:0]             csr_index = '0;
   logic [15:0]            csr_data = '0;

   radio_link_session_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Events waiting for the driver, the event on the bus and the message items still owed.
   sess_evt_type pending_events[$];
   sess_evt_type evt_on_bus;
   item_type  due_msgs[$];
   item_type  new_msgs[$];

   int  events_queued = 0;
   int  events_sent = 0;
   int  msgs_checked = 0;
   int  mismatches = 0;
   int  settings_used = 0;
   int  cycles = 0;
   bit  steady = 1'b0;

   // Register copies held by the predictor.
   logic        cfg_auth_req = 1'b0;
   logic [15:0] cfg_hs_to    = HS_TO_RESET;
   logic [15:0] cfg_auth_to  = AUTH_TO_RESET;
   logic [15:0] cfg_cfg_to   = CFG_TO_RESET;
   logic [15:0] cfg_tx_to    = TX_TO_RESET;
   logic [15:0] cfg_ping_iv  = PING_IV_RESET;
   logic [15:0] cfg_pong_to  = PONG_TO_RESET;

   // Session state held by the predictor.
   phase_type   sess_phase = PH_CLOSED;
   logic [3:0]  close_reason = CC_NONE;
   logic        deadline_on = 1'b0;
   logic [15:0] deadline_left = '0;
   logic [3:0]  deadline_reason = CC_NONE;
   logic        tx_inflight = 1'b0;
   logic [15:0] tx_seq = '0;
   logic [15:0] tx_left = '0;
   logic        awaiting_pong = 1'b0;
   logic [15:0] ping_left = '0;
   logic [15:0] pong_left = '0;

   function automatic void emit(logic [2:0] mt, logic [15:0] sq, logic [1:0] cd);
      item_type m;
      m = '0;
      m.msg_type = mt;
      m.seq = sq;
      m.code = cd;
      new_msgs.push_back(m);
   endfunction

   // A close only counts when the session is still open, so the first reason sticks.
   function automatic void shut(logic [3:0] why);
      if (sess_phase == PH_CLOSED) return;
      close_reason = why;
      sess_phase = PH_CLOSED;
      deadline_on = 1'b0;
      tx_inflight = 1'b0;
   endfunction

   function automatic void arm_deadline(logic [15:0] ticks, logic [3:0] why);
      deadline_on = 1'b1;
      deadline_left = ticks;
      deadline_reason = why;
   endfunction

   // Received frame, checked against the phase the session is in.
   function automatic void take_frame(sess_evt_type e);
      if (sess_phase == PH_CLOSED) return;
      if (!e.fvalid) begin
         shut(CC_MALFORMED);
         return;
      end
      if (e.ftype >= FT_SERVER) begin
         shut(CC_BADSTATE);
         return;
      end
      if (e.ftype == FT_ERROR) begin
         shut(CC_REMOTE);
         return;
      end
      case (sess_phase)
         PH_HELLO: begin
            if (e.ftype != FT_HELLO) begin
               shut(CC_BADSTATE);
               return;
            end
            emit(MSG_GREET_ACK, '0, CODE_OK);
            if (cfg_auth_req) begin
               if (!e.nonce_ok) begin
                  shut(CC_AUTHERR);
                  return;
               end
               emit(MSG_CHALLENGE, '0, CODE_OK);
               sess_phase = PH_AUTH;
               arm_deadline(cfg_auth_to, CC_AUTH_TO);
            end else begin
               emit(MSG_AUTH_RES, '0, CODE_OK);
               sess_phase = PH_CFG;
               arm_deadline(cfg_cfg_to, CC_CFG_TO);
            end
         end
         PH_AUTH: begin
            if (e.ftype != FT_AUTH_RESP) begin
               shut(CC_BADSTATE);
               return;
            end
            if (e.auth_ok) begin
               emit(MSG_AUTH_RES, '0, CODE_OK);
               sess_phase = PH_CFG;
               arm_deadline(cfg_cfg_to, CC_CFG_TO);
            end else begin
               emit(MSG_AUTH_RES, '0, CODE_FAIL);
               shut(CC_AUTHFAIL);
            end
         end
         PH_CFG: begin
            if (e.ftype != FT_CONFIGURE) begin
               shut(CC_BADSTATE);
            end else if (!e.cfg_valid) begin
               emit(MSG_CFG_RES, '0, CODE_FAIL);
               shut(CC_CFGFAIL);
            end else if (!e.cfg_match) begin
               emit(MSG_CFG_RES, '0, CODE_UNSUPPORTED);
               shut(CC_CFGFAIL);
            end else begin
               emit(MSG_CFG_RES, '0, CODE_OK);
               sess_phase = PH_READY;
               deadline_on = 1'b0;
               awaiting_pong = 1'b0;
               ping_left = cfg_ping_iv;
            end
         end
         default: begin
            // Ready: only pongs and transmit requests are legal here.
            if (e.ftype == FT_PONG) begin
               if (!awaiting_pong) begin
                  shut(CC_BADSTATE);
                  return;
               end
               awaiting_pong = 1'b0;
               ping_left = cfg_ping_iv;
            end else if (e.ftype == FT_TX_REQ) begin
               if (tx_inflight) begin
                  shut(CC_BADSTATE);
                  return;
               end
               tx_seq = e.fseq;
               if (!e.submit_ok) begin
                  shut(CC_BACKEND);
                  return;
               end
               tx_inflight = 1'b1;
               tx_left = cfg_tx_to;
            end else begin
               shut(CC_BADSTATE);
            end
         end
      endcase
   endfunction

   // Millisecond tick: every running countdown moves first, then they are checked in
   // order of priority. Returns whether the pending transmit must be abandoned.
   function automatic bit take_tick();
      if (sess_phase == PH_CLOSED) return 1'b0;
      if (deadline_on && deadline_left != 0) deadline_left = deadline_left - 16'd1;
      if (tx_inflight && tx_left != 0) tx_left = tx_left - 16'd1;
      if (awaiting_pong) begin
         if (pong_left != 0) pong_left = pong_left - 16'd1;
      end else if (ping_left != 0) begin
         ping_left = ping_left - 16'd1;
      end
      if (deadline_on && deadline_left == 0) begin
         shut(deadline_reason);
         return 1'b0;
      end
      if (sess_phase != PH_READY) return 1'b0;
      if (tx_inflight && tx_left == 0) begin
         shut(CC_TX_TO);
         return 1'b1;
      end
      if (awaiting_pong) begin
         if (pong_left == 0) shut(CC_PONG_TO);
      end else if (ping_left == 0) begin
         emit(MSG_KEEPALIVE, '0, CODE_OK);
         awaiting_pong = 1'b1;
         pong_left = cfg_pong_to;
      end
      return 1'b0;
   endfunction

   // Works out the message items that one accepted event owes and queues them.
   function automatic void advance_session(sess_evt_type e);
      logic abandon;
      abandon = 1'b0;
      new_msgs.delete();
      case (e.mode)
         MODE_OPEN: begin
            sess_phase = PH_HELLO;
            close_reason = CC_NONE;
            tx_inflight = 1'b0;
            awaiting_pong = 1'b0;
            arm_deadline(cfg_hs_to, CC_HS_TO);
         end
         MODE_FRAME:   take_frame(e);
         MODE_TICK:    abandon = take_tick();
         MODE_TXDONE: begin
            if (tx_inflight) begin
               tx_inflight = 1'b0;
               emit(MSG_TX_RES, tx_seq, e.outcome);
            end
         end
         MODE_BACKEND: shut(CC_BACKEND);
         MODE_RX: begin
            if (sess_phase == PH_READY && e.rx_ok) emit(MSG_RX_PKT, '0, CODE_OK);
         end
         MODE_PARSER:  shut(CC_PARSER);
         default: ;
      endcase
      if (new_msgs.size() == 0) emit(MSG_NONE, '0, CODE_OK);
      foreach (new_msgs[k]) begin
         new_msgs[k].phase = sess_phase;
         new_msgs[k].cause = close_reason;
         new_msgs[k].abandon = abandon;
         new_msgs[k].last = (k == new_msgs.size() - 1);
         due_msgs.push_back(new_msgs[k]);
      end
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Request driver: holds each event until its transaction completes, idling at random.
   always @(posedge clock) begin
      sess_evt_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_session(evt_on_bus);
            events_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
               nxt = pending_events.pop_front();
               evt_on_bus <= nxt;
               req_tdata <= {4'b0, nxt.rx_ok, nxt.outcome, nxt.fseq, nxt.submit_ok,
                             nxt.cfg_match, nxt.cfg_valid, nxt.nonce_ok, nxt.auth_ok,
                             nxt.fvalid, nxt.ftype};
               req_tuser <= nxt.mode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each message item against the oldest one owed.
   always @(posedge clock) begin
      item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            msgs_checked++;
            if (due_msgs.size() == 0) begin
               $error("Unexpected message item of type %0d", rsp_tuser);
               mismatches++;
            end else begin
               want = due_msgs.pop_front();
               compare_field("msg_type", 32'(want.msg_type), 32'(rsp_tuser));
               compare_field("msg_seq", 32'(want.seq), 32'(rsp_tdata[15:0]));
               compare_field("msg_code", 32'(want.code), 32'(rsp_tdata[17:16]));
               compare_field("phase_now", 32'(want.phase), 32'(rsp_tdata[20:18]));
               compare_field("close_cause", 32'(want.cause), 32'(rsp_tdata[24:21]));
               compare_field("abandon_tx", 32'(want.abandon), 32'(rsp_tdata[25]));
               compare_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= GAP_PCT);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d items still owed", cycles, due_msgs.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic void put(sess_evt_type e);
      pending_events.push_back(e);
      events_queued++;
   endfunction

   // Event with every check passing and random payload fields.
   function automatic sess_evt_type well_formed(logic [2:0] md, logic [2:0] ft);
      sess_evt_type e;
      e.mode = md;
      e.ftype = ft;
      e.fvalid = 1'b1;
      e.auth_ok = 1'b1;
      e.nonce_ok = 1'b1;
      e.cfg_valid = 1'b1;
      e.cfg_match = 1'b1;
      e.submit_ok = 1'b1;
      e.fseq = 16'($urandom_range(16'hFFFF));
      e.outcome = 2'($urandom_range(3));
      e.rx_ok = 1'b1;
      return e;
   endfunction

   function automatic sess_evt_type noise_evt();
      sess_evt_type e;
      e = well_formed(3'($urandom_range(7)), 3'($urandom_range(7)));
      e.fvalid = 1'($urandom_range(1));
      e.auth_ok = 1'($urandom_range(1));
      e.nonce_ok = 1'($urandom_range(1));
      e.cfg_valid = 1'($urandom_range(1));
      e.cfg_match = 1'($urandom_range(1));
      e.submit_ok = 1'($urandom_range(1));
      e.rx_ok = 1'($urandom_range(1));
      return e;
   endfunction

   function automatic void queue_ticks();
      repeat ($urandom_range(1, 8)) put(well_formed(MODE_TICK, 3'($urandom_range(7))));
   endfunction

   // One session from open to close: mostly legal handshakes with some broken steps,
   // then a stretch of ready-phase traffic mixed with ticks and noise.
   function automatic void queue_session();
      sess_evt_type e;
      int roll;
      if (chance(95)) put(well_formed(MODE_OPEN, 3'($urandom_range(7))));
      else put(noise_evt());
      if (chance(15)) queue_ticks();
      e = well_formed(MODE_FRAME, FT_HELLO);
      e.fvalid = chance(96);
      e.nonce_ok = chance(90);
      if (chance(5)) e.ftype = 3'($urandom_range(7));
      put(e);
      if (cfg_auth_req) begin
         if (chance(15)) queue_ticks();
         e = well_formed(MODE_FRAME, FT_AUTH_RESP);
         e.auth_ok = chance(85);
         e.fvalid = chance(96);
         put(e);
      end
      if (chance(15)) queue_ticks();
      e = well_formed(MODE_FRAME, FT_CONFIGURE);
      e.cfg_valid = chance(90);
      e.cfg_match = chance(90);
      e.fvalid = chance(96);
      put(e);
      repeat ($urandom_range(4, 30)) begin
         roll = $urandom_range(99);
         if (roll < 35) begin
            queue_ticks();
         end else if (roll < 50) begin
            e = well_formed(MODE_FRAME, FT_TX_REQ);
            e.submit_ok = chance(90);
            put(e);
         end else if (roll < 63) begin
            put(well_formed(MODE_TXDONE, 3'($urandom_range(7))));
         end else if (roll < 73) begin
            put(well_formed(MODE_FRAME, FT_PONG));
         end else if (roll < 87) begin
            e = well_formed(MODE_RX, 3'($urandom_range(7)));
            e.rx_ok = chance(80);
            put(e);
         end else begin
            put(noise_evt());
         end
      end
   endfunction

   // Register write on the configuration channel; the predictor copy follows on acceptance.
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         REG_AUTH_REQ: cfg_auth_req = val[0];
         REG_HS_TO:    cfg_hs_to = val;
         REG_AUTH_TO:  cfg_auth_to = val;
         REG_CFG_TO:   cfg_cfg_to = val;
         REG_TX_TO:    cfg_tx_to = val;
         REG_PING_IV:  cfg_ping_iv = val;
         REG_PONG_TO:  cfg_pong_to = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(logic auth, logic [15:0] hs, logic [15:0] au, logic [15:0] cf,
                                logic [15:0] tx, logic [15:0] pi, logic [15:0] po);
      write_reg(REG_AUTH_REQ, {15'b0, auth});
      write_reg(REG_HS_TO, hs);
      write_reg(REG_AUTH_TO, au);
      write_reg(REG_CFG_TO, cf);
      write_reg(REG_TX_TO, tx);
      write_reg(REG_PING_IV, pi);
      write_reg(REG_PONG_TO, po);
      settings_used++;
      @(negedge clock);
   endtask

   // Queues sessions until the given number of events is reached, then waits for the
   // block to go idle with every owed item delivered.
   task automatic run_traffic(int count);
      int target;
      target = events_queued + count;
      while (events_queued < target) queue_session();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || due_msgs.size() != 0);
   endtask

   task automatic small_timeouts();
      apply_setting(1'($urandom_range(1)), 16'($urandom_range(1, 12)),
                    16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                    16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                    16'($urandom_range(1, 12)));
   endtask

   initial begin
      sess_evt_type e;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      settings_used = 1;

      // Directed: a full session at the reset settings, then several ways of closing.
      put(well_formed(MODE_OPEN, FT_HELLO));
      put(well_formed(MODE_FRAME, FT_HELLO));
      put(well_formed(MODE_FRAME, FT_CONFIGURE));
      e = well_formed(MODE_FRAME, FT_TX_REQ);
      e.fseq = 16'hFFFF;
      put(e);
      put(well_formed(MODE_RX, FT_HELLO));
      e = well_formed(MODE_RX, FT_HELLO);
      e.rx_ok = 1'b0;
      put(e);
      e = well_formed(MODE_TXDONE, FT_HELLO);
      e.outcome = 2'd3;
      put(e);
      put(well_formed(MODE_TXDONE, FT_HELLO));   // stale completion
      e = well_formed(MODE_FRAME, FT_TX_REQ);
      e.fseq = 16'h0000;
      put(e);
      put(well_formed(MODE_TICK, FT_HELLO));
      e = well_formed(MODE_TXDONE, FT_HELLO);
      e.outcome = 2'd0;
      put(e);
      put(well_formed(MODE_FRAME, FT_PONG));      // pong without a ping
      put(well_formed(MODE_FRAME, FT_HELLO));     // ignored while closed
      put(well_formed(MODE_TICK, FT_HELLO));
      put(well_formed(3'd7, FT_HELLO));           // unknown event kind
      put(well_formed(MODE_OPEN, FT_HELLO));
      put(well_formed(MODE_FRAME, 3'd7));         // unknown frame type
      put(well_formed(MODE_OPEN, FT_HELLO));
      e = well_formed(MODE_FRAME, FT_HELLO);
      e.fvalid = 1'b0;
      put(e);
      put(well_formed(MODE_OPEN, FT_HELLO));
      put(well_formed(MODE_FRAME, FT_ERROR));
      put(well_formed(MODE_OPEN, FT_HELLO));
      put(well_formed(MODE_PARSER, FT_HELLO));
      put(well_formed(MODE_BACKEND, FT_HELLO));   // second close keeps the first reason
      run_traffic(125);

      // Authentication on, short timers.
      apply_setting(1'b1, 16'd3, 16'd2, 16'd4, 16'd5, 16'd3, 16'd2);
      run_traffic(300);

      // Zero timeouts expire on the very first tick.
      apply_setting(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_traffic(200);

      // Largest timeouts, and a stretch with no idling on either side.
      steady = 1'b1;
      apply_setting(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_traffic(200);
      steady = 1'b0;

      // Random short timers.
      small_timeouts();
      run_traffic(250);
      small_timeouts();
      run_traffic(250);

      repeat (8) @(posedge clock);
      $display("Ran %0d events over %0d register settings; %0d message items checked.",
               events_sent, settings_used, msgs_checked);
      $display("Sessions covered auth on and off, every close reason path and all timers.");
      if (mismatches == 0 && due_msgs.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
